### sv/fidg_pkg.sv
// Shared constants, types and state encoding for the firmware image digest generator.
package fidg_pkg;

	// Hash seed and generator constants
	localparam logic [31:0] SEED     = 32'h9E37_79B9;
	localparam logic [31:0] LCG_MUL  = 32'd1103515245;
	localparam logic [31:0] LCG_ADD  = 32'd12345;

	// Digest sizing
	localparam int HASH_BYTES_DEF = 32;
	localparam int MAX_DIGEST     = 32;
	localparam int IDX_W          = 5;

	// Controller states
	typedef enum logic {
		ST_ABSORB,
		ST_EXPAND
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic absorb;   // fold the input byte into the running hash
		logic start;    // seed the generator with the final hash, reset the hash
		logic emit;     // step the generator and load the output register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic idx_last; // generator is on the final digest byte
	} status_t;

endpackage

### sv/firmware_image_digest_generator.sv
// Top level of the firmware image digest generator.
//
// Input channel (in_valid / in_stall) carries one image byte per transaction:
// data_byte, byte_present (absorb the byte) and last_byte (end of image).
// A transaction with byte_present low and last_byte high closes an empty image.
// Bytes are absorbed at one per cycle, outside expansion, into a 32-bit running hash.
// On the last transaction the hash seeds a 32-bit generator, one multiply and
// add per step, and the block sends max(1, min(HASH_BYTES, 32)) digest
// transactions on the output channel (out_valid / out_stall): digest_byte,
// digest_index, digest_last. Once the generator is seeded, digest bytes are
// loaded into the output register one per cycle while the receiver does not
// stall; the generator register step sets that rate. in_stall is high during
// expansion, so no image byte is taken while the digest is produced.
// When the receiver stalls, the output register holds its transaction and
// expansion pauses. Absorbing resumes right after the final digest byte is
// loaded, even while it still waits to be taken.
// Reset clears both valid/state registers and returns the hash to its seed.
module firmware_image_digest_generator #(
	parameter int HASH_BYTES = fidg_pkg::HASH_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 data_byte,
	input  logic                       byte_present,
	input  logic                       last_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 digest_byte,
	output logic [fidg_pkg::IDX_W-1:0] digest_index,
	output logic                       digest_last
);

	fidg_pkg::cmd_t    cmd;
	fidg_pkg::status_t status;

	// Sequence the run
	fidg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.byte_present (byte_present),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.status       (status)
	);

	// Hash and generate
	fidg_datapath #(
		.HASH_BYTES (HASH_BYTES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.data_byte    (data_byte),
		.digest_byte  (digest_byte),
		.digest_index (digest_index),
		.digest_last  (digest_last)
	);

endmodule

### sv/fidg_datapath.sv
// Datapath: running hash, digest generator and output payload registers.
module fidg_datapath #(
	parameter int HASH_BYTES = fidg_pkg::HASH_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  fidg_pkg::cmd_t             cmd,
	output fidg_pkg::status_t          status,
	input  logic [7:0]                 data_byte,
	output logic [7:0]                 digest_byte,
	output logic [fidg_pkg::IDX_W-1:0] digest_index,
	output logic                       digest_last
);

	// Number of digest bytes per run, clamped to the index span and at least one
	localparam int LEN_SAT = (HASH_BYTES > fidg_pkg::MAX_DIGEST) ? fidg_pkg::MAX_DIGEST
	                                                              : HASH_BYTES;
	localparam int DIGEST_LEN = (LEN_SAT < 1) ? 1 : LEN_SAT;
	localparam logic [fidg_pkg::IDX_W-1:0] LAST_IDX = fidg_pkg::IDX_W'(DIGEST_LEN - 1);

	logic [31:0]                hash_q;
	logic [31:0]                x_q;
	logic [fidg_pkg::IDX_W-1:0] idx_q;
	logic [31:0]                mixed;
	logic [31:0]                hash_n;
	logic [31:0]                x_n;

	// Absorb step: xor the byte in, then add the shifted copies
	always_comb begin
		mixed  = hash_q ^ {24'd0, data_byte};
		hash_n = cmd.absorb ? (mixed + (mixed << 6) + (mixed >> 2)) : hash_q;
	end

	// One generator step
	assign x_n = x_q * fidg_pkg::LCG_MUL + fidg_pkg::LCG_ADD;

	assign status.idx_last = (idx_q == LAST_IDX);

	// Hold the running hash; return it to the seed once the digest starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= fidg_pkg::SEED;
		end else if (cmd.start) begin
			hash_q <= fidg_pkg::SEED;
		end else if (cmd.absorb) begin
			hash_q <= hash_n;
		end
	end

	// Advance the generator and the digest position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.start) begin
			idx_q <= '0;
		end else if (cmd.emit) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= hash_n;
		end else if (cmd.emit) begin
			x_q <= x_n;
		end
	end

	// Load the output payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			digest_byte  <= x_n[23:16];
			digest_index <= idx_q;
			digest_last  <= status.idx_last;
		end
	end

endmodule

### sv/fidg_ctrl.sv
// Controller: sequences absorb and digest expansion, owns both handshakes.
module fidg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               byte_present,
	input  logic               last_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output fidg_pkg::cmd_t     cmd,
	input  fidg_pkg::status_t  status
);

	fidg_pkg::state_t state_q;
	fidg_pkg::state_t state_n;
	logic             out_valid_q;
	logic             out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fidg_pkg::ST_ABSORB;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and commands
	always_comb begin
		state_n    = state_q;
		in_stall   = 1'b1;
		cmd.absorb = 1'b0;
		cmd.start  = 1'b0;
		cmd.emit   = 1'b0;
		case (state_q)
			fidg_pkg::ST_ABSORB: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.absorb = byte_present;
					if (last_byte) begin
						cmd.start = 1'b1;
						state_n   = fidg_pkg::ST_EXPAND;
					end
				end
			end
			fidg_pkg::ST_EXPAND: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					if (status.idx_last) begin
						state_n = fidg_pkg::ST_ABSORB;
					end
				end
			end
			default: begin
				state_n = fidg_pkg::ST_ABSORB;
			end
		endcase
	end

	// Set valid on a load, drop it once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
